### rtl/gn_pkg.sv
package gn_pkg;

   localparam int PERIOD_W = 16;
   localparam int NOISE_W  = 18;
   localparam int HASH_SHIFT = 8;

   // Fade polynomial coefficients: t*t*t*(t*(6t-15)+10).
   localparam int FADE_A = 6;
   localparam int FADE_B = 15;
   localparam int FADE_C = 10;

   typedef enum logic [1:0] {
      CSR_MULT_ONE   = 2'd0,
      CSR_ADD_TWO    = 2'd1,
      CSR_MULT_THREE = 2'd2
   } csr_index_type;

   localparam logic [31:0] MULT_ONE_RST   = 32'hB529_7A4D;
   localparam logic [31:0] ADD_TWO_RST    = 32'h68E3_1DA4;
   localparam logic [31:0] MULT_THREE_RST = 32'h1B56_C4E9;

   localparam logic signed [31:0] NOISE_MAX = 32'sd131071;
   localparam logic signed [31:0] NOISE_MIN = -32'sd131072;

   typedef struct packed {
      logic [31:0] mult_one;
      logic [31:0] add_two;
      logic [31:0] mult_three;
   } hash_key_type;

endpackage

### rtl/gradient_noise_2d_tileable.sv
// Tileable 2D gradient noise, fully pipelined: one word is taken on every cycle
// that start is high and its result appears for one cycle with rsp_valid high.
// The depth is set mostly by the wrap remainder, which resolves one bit of the
// cell index per stage, followed by six hash stages and five blend stages. busy
// stays low, and results cannot be held off, so the receiver must take every
// word. The hash constants may only be rewritten while no word is in flight.
module gradient_noise_2d_tileable import gn_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [31:0]        req_coord_x,
   input  logic signed [31:0]        req_coord_y,
   input  logic [31:0]               req_hash_seed,
   input  logic [PERIOD_W-1:0]       req_tile_period,
   input  logic                      csr_wr_en,
   input  logic [1:0]                csr_index,
   input  logic [31:0]               csr_wdata,
   output logic                      rsp_valid,
   output logic signed [NOISE_W-1:0] rsp_noise_value
);

   localparam int F   = FRAC_BITS;
   localparam int W   = 32 - F;
   localparam int LAT = W + 12;
   localparam int SW  = 2 * W + 2 * F + 32;

   hash_key_type key_ff;
   logic [LAT-1:0] valid_ff;

   logic signed [W-1:0] cx0x, cy0y, cx0_d, cy0_d;
   logic signed [W:0]   cx1x, cy1y, cx1_w, cy1_w;
   logic [31:0]         seed_d;
   logic [F-1:0]        fx_d, fy_d, fx_b, fy_b;
   logic [F:0]          ux, vy, ux_d, vy_d;
   logic [31:0]         h00, h01, h10, h11;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff.mult_one   <= MULT_ONE_RST;
         key_ff.add_two    <= ADD_TWO_RST;
         key_ff.mult_three <= MULT_THREE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MULT_ONE:   key_ff.mult_one   <= csr_wdata;
            CSR_ADD_TWO:    key_ff.add_two    <= csr_wdata;
            CSR_MULT_THREE: key_ff.mult_three <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[LAT-2:0], start && !busy};
      end
   end

   assign busy      = 1'b0;
   assign rsp_valid = valid_ff[LAT-1];

   // Cell index is the floor of the coordinate; the far corner is one beyond.
   always_comb begin
      cx0x = $signed(req_coord_x[31:F]);
      cy0y = $signed(req_coord_y[31:F]);
      cx1x = {cx0x[W-1], cx0x} + 1'b1;
      cy1y = {cy0y[W-1], cy0y} + 1'b1;
   end

   gn_wrap #(.W(W)) u_wrap_x (
      .clock(clock), .value(cx1x), .period(req_tile_period), .result(cx1_w)
   );
   gn_wrap #(.W(W)) u_wrap_y (
      .clock(clock), .value(cy1y), .period(req_tile_period), .result(cy1_w)
   );

   gn_delay #(.WIDTH(SW), .DEPTH(W + 1)) u_side_delay (
      .clock(clock),
      .din({cx0x, cy0y, req_hash_seed, req_coord_x[F-1:0], req_coord_y[F-1:0]}),
      .dout({cx0_d, cy0_d, seed_d, fx_d, fy_d})
   );

   gn_hash u_hash (
      .clock(clock),
      .key(key_ff),
      .seed(seed_d),
      .cx0({{F{cx0_d[W-1]}}, cx0_d}),
      .cx1({{(F-1){cx1_w[W]}}, cx1_w}),
      .cy0({{F{cy0_d[W-1]}}, cy0_d}),
      .cy1({{(F-1){cy1_w[W]}}, cy1_w}),
      .h00(h00), .h01(h01), .h10(h10), .h11(h11)
   );

   gn_fade #(.FRAC_BITS(F)) u_fade_x (
      .clock(clock), .t(req_coord_x[F-1:0]), .fade(ux)
   );
   gn_fade #(.FRAC_BITS(F)) u_fade_y (
      .clock(clock), .t(req_coord_y[F-1:0]), .fade(vy)
   );

   gn_delay #(.WIDTH(2 * (F + 1)), .DEPTH(W + 3)) u_fade_delay (
      .clock(clock), .din({ux, vy}), .dout({ux_d, vy_d})
   );

   gn_delay #(.WIDTH(2 * F), .DEPTH(6)) u_frac_delay (
      .clock(clock), .din({fx_d, fy_d}), .dout({fx_b, fy_b})
   );

   gn_blend #(.FRAC_BITS(F)) u_blend (
      .clock(clock),
      .h00(h00), .h01(h01), .h10(h10), .h11(h11),
      .fx(fx_b), .fy(fy_b), .u(ux_d), .v(vy_d),
      .noise(rsp_noise_value)
   );

endmodule

### rtl/gn_delay.sv
module gn_delay import gn_pkg::*; #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      line_ff[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
         line_ff[i] <= line_ff[i-1];
      end
   end

   assign dout = line_ff[DEPTH-1];

endmodule

### rtl/gn_fade.sv
module gn_fade import gn_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic [FRAC_BITS-1:0] t,
   output logic [FRAC_BITS:0]   fade
);

   localparam int F  = FRAC_BITS;
   localparam int TW = 2 * F;
   localparam int AW = F + 5;
   localparam int IW = 2 * F + 6;
   localparam int NW = F + 4;
   localparam int PW = 2 * F + 4;

   logic [F-1:0]           t1_ff;
   logic [TW-1:0]          tt_ff, tt_in;
   logic signed [AW-1:0]   a_ff, a_in;
   logic [TW-1:0]          t3p_ff, t3p_in;
   logic signed [IW-1:0]   inp_ff, inp_in;
   logic signed [F:0]      t_sig;
   logic [F-1:0]           tsq;
   logic [F-1:0]           t3_ff, t3_in;
   logic signed [IW-1:0]   inner_sum;
   logic [NW-1:0]          inner_ff, inner_in;
   logic [PW-1:0]          fp;
   logic [F:0]             fade_ff, fade_in;

   always_comb begin
      tt_in  = TW'(t) * TW'(t);
      a_in   = $signed(AW'(FADE_A) * AW'(t) - (AW'(FADE_B) << F));
      tsq    = tt_ff[TW-1:F];
      t_sig  = $signed({1'b0, t1_ff});
      t3p_in = TW'(tsq) * TW'(t1_ff);
      inp_in = IW'(t_sig) * IW'(a_ff);
      t3_in  = t3p_ff[TW-1:F];
      // The inner polynomial stays positive over [0,1), so it is kept unsigned.
      inner_sum = (inp_ff >>> F) + (IW'(FADE_C) << F);
      inner_in  = inner_sum[NW-1:0];
      fp      = PW'(t3_ff) * PW'(inner_ff);
      fade_in = fp[F +: F+1];
   end

   always_ff @(posedge clock) begin
      t1_ff    <= t;
      tt_ff    <= tt_in;
      a_ff     <= a_in;
      t3p_ff   <= t3p_in;
      inp_ff   <= inp_in;
      t3_ff    <= t3_in;
      inner_ff <= inner_in;
      fade_ff  <= fade_in;
   end

   assign fade = fade_ff;

endmodule

### rtl/gn_wrap.sv
module gn_wrap import gn_pkg::*; #(
   parameter int W = 16
) (
   input  logic                clock,
   input  logic signed [W:0]   value,
   input  logic [PERIOD_W-1:0] period,
   output logic signed [W:0]   result
);

   localparam int RW = PERIOD_W + 1;

   logic [W-1:0]          mag_ff   [0:W];
   logic [PERIOD_W-1:0]   rem_ff   [0:W];
   logic [PERIOD_W-1:0]   per_ff   [0:W];
   logic                  neg_ff   [0:W];
   logic signed [W:0]     raw_ff   [0:W];
   logic signed [W:0]     neg_val;
   logic [W-1:0]          mag_in;
   logic [31:0]           rem_wide;
   logic signed [W:0]     rem_w;

   always_comb begin
      neg_val = -value;
      mag_in  = value[W] ? neg_val[W-1:0] : value[W-1:0];
   end

   always_ff @(posedge clock) begin
      mag_ff[0] <= mag_in;
      rem_ff[0] <= '0;
      per_ff[0] <= period;
      neg_ff[0] <= value[W];
      raw_ff[0] <= value;
   end

   // Restoring division of the magnitude, one quotient bit per stage.
   for (genvar k = 0; k < W; k++) begin : g_step
      logic [RW-1:0]       trial;
      logic [RW-1:0]       diff;
      logic [PERIOD_W-1:0] rem_in;

      always_comb begin
         trial  = {rem_ff[k], mag_ff[k][W-1-k]};
         diff   = trial - {1'b0, per_ff[k]};
         rem_in = (trial >= {1'b0, per_ff[k]}) ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
      end

      always_ff @(posedge clock) begin
         mag_ff[k+1] <= mag_ff[k];
         rem_ff[k+1] <= rem_in;
         per_ff[k+1] <= per_ff[k];
         neg_ff[k+1] <= neg_ff[k];
         raw_ff[k+1] <= raw_ff[k];
      end
   end

   // The remainder never exceeds the magnitude, so it fits the value width.
   always_comb begin
      rem_wide = 32'(rem_ff[W]);
      rem_w    = $signed(rem_wide[W:0]);
      if (per_ff[W] == '0) begin
         result = raw_ff[W];
      end else if (neg_ff[W]) begin
         result = -rem_w;
      end else begin
         result = rem_w;
      end
   end

endmodule

### rtl/gn_squirrel.sv
module gn_squirrel import gn_pkg::*; (
   input  logic         clock,
   input  logic [31:0]  pos,
   input  logic [31:0]  seed,
   input  hash_key_type key,
   output logic [31:0]  hash,
   output logic [31:0]  seed_out
);

   logic [31:0] prod_ff, prod_in;
   logic [31:0] seed1_ff, seed2_ff, seed3_ff;
   logic [31:0] mix_ff, mix_in;
   logic [31:0] hash_ff, hash_in;
   logic [31:0] m_a, m_b, m_c, q;

   always_comb begin
      prod_in = pos * key.mult_one;
      m_a     = prod_ff + seed1_ff;
      m_b     = (m_a ^ (m_a >> HASH_SHIFT)) + key.add_two;
      m_c     = m_b ^ (m_b << HASH_SHIFT);
      mix_in  = m_c;
      q       = mix_ff * key.mult_three;
      hash_in = q ^ (q >> HASH_SHIFT);
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      seed1_ff <= seed;
      mix_ff   <= mix_in;
      seed2_ff <= seed1_ff;
      hash_ff  <= hash_in;
      seed3_ff <= seed2_ff;
   end

   assign hash     = hash_ff;
   assign seed_out = seed3_ff;

endmodule

### rtl/gn_hash.sv
module gn_hash import gn_pkg::*; (
   input  logic         clock,
   input  hash_key_type key,
   input  logic [31:0]  seed,
   input  logic [31:0]  cx0,
   input  logic [31:0]  cx1,
   input  logic [31:0]  cy0,
   input  logic [31:0]  cy1,
   output logic [31:0]  h00,
   output logic [31:0]  h01,
   output logic [31:0]  h10,
   output logic [31:0]  h11
);

   logic [31:0] hx0, hx1, seed_d;
   logic [31:0] cy0_d, cy1_d;

   // Column hashes are shared by both rows of the cell.
   gn_squirrel u_col0 (
      .clock(clock), .pos(cx0), .seed(seed), .key(key), .hash(hx0), .seed_out(seed_d)
   );
   gn_squirrel u_col1 (
      .clock(clock), .pos(cx1), .seed(seed), .key(key), .hash(hx1), .seed_out()
   );

   gn_delay #(.WIDTH(64), .DEPTH(3)) u_cy_delay (
      .clock(clock), .din({cy0, cy1}), .dout({cy0_d, cy1_d})
   );

   gn_squirrel u_c00 (
      .clock(clock), .pos(hx0 + cy0_d), .seed(seed_d), .key(key), .hash(h00), .seed_out()
   );
   gn_squirrel u_c01 (
      .clock(clock), .pos(hx0 + cy1_d), .seed(seed_d), .key(key), .hash(h01), .seed_out()
   );
   gn_squirrel u_c10 (
      .clock(clock), .pos(hx1 + cy0_d), .seed(seed_d), .key(key), .hash(h10), .seed_out()
   );
   gn_squirrel u_c11 (
      .clock(clock), .pos(hx1 + cy1_d), .seed(seed_d), .key(key), .hash(h11), .seed_out()
   );

endmodule

### rtl/gn_blend.sv
module gn_blend import gn_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic [31:0]               h00,
   input  logic [31:0]               h01,
   input  logic [31:0]               h10,
   input  logic [31:0]               h11,
   input  logic [FRAC_BITS-1:0]      fx,
   input  logic [FRAC_BITS-1:0]      fy,
   input  logic [FRAC_BITS:0]        u,
   input  logic [FRAC_BITS:0]        v,
   output logic signed [NOISE_W-1:0] noise
);

   localparam int F  = FRAC_BITS;
   localparam int GW = F + 3;
   localparam int DW = F + 4;
   localparam int UW = F + 2;
   localparam int PW = DW + UW;
   localparam int LW = F + 5;
   localparam int QW = LW + UW;
   localparam int RW = F + 6;
   localparam logic signed [GW-1:0] ONE_Q = GW'(1 << F);

   function automatic logic signed [GW-1:0] grad(
      input logic [31:0]          h,
      input logic signed [GW-1:0] dx,
      input logic signed [GW-1:0] dy
   );
      logic signed [GW-1:0] gx;
      logic signed [GW-1:0] gy;
      gx = h[1] ? -dx : dx;
      gy = h[0] ? -dy : dy;
      return gx + gy;
   endfunction

   logic signed [GW-1:0] dx0, dx1, dy0, dy1;
   logic signed [GW-1:0] g00, g01, g10, g11;
   logic signed [GW-1:0] a0_ff, a1_ff, a0_2_ff, a1_2_ff;
   logic signed [DW-1:0] d0_ff, d1_ff, d0_in, d1_in;
   logic [F:0]           u1_ff, v1_ff, v2_ff, v3_ff;
   logic signed [UW-1:0] u_sig, v_sig;
   logic signed [PW-1:0] p0_ff, p1_ff, p0_in, p1_in;
   logic signed [LW-1:0] low_in, high_in, diff2_in;
   logic signed [LW-1:0] low_ff, diff2_ff, low4_ff;
   logic signed [QW-1:0] q_ff, q_in;
   logic signed [RW-1:0] r;
   logic signed [31:0]   r_wide;
   logic signed [NOISE_W-1:0] noise_ff, noise_in;

   always_comb begin
      dx0   = $signed(GW'(fx));
      dy0   = $signed(GW'(fy));
      dx1   = dx0 - ONE_Q;
      dy1   = dy0 - ONE_Q;
      g00   = grad(h00, dx0, dy0);
      g10   = grad(h10, dx1, dy0);
      g01   = grad(h01, dx0, dy1);
      g11   = grad(h11, dx1, dy1);
      d0_in = DW'(g10) - DW'(g00);
      d1_in = DW'(g11) - DW'(g01);

      u_sig = $signed({1'b0, u1_ff});
      p0_in = PW'(u_sig) * PW'(d0_ff);
      p1_in = PW'(u_sig) * PW'(d1_ff);

      // Arithmetic shifts give the floor of each product.
      low_in   = LW'(a0_2_ff) + LW'(p0_ff >>> F);
      high_in  = LW'(a1_2_ff) + LW'(p1_ff >>> F);
      diff2_in = high_in - low_in;

      v_sig = $signed({1'b0, v3_ff});
      q_in  = QW'(v_sig) * QW'(diff2_ff);

      r      = RW'(low4_ff) + RW'(q_ff >>> F);
      r_wide = 32'(r);
      if (r_wide > NOISE_MAX) begin
         noise_in = NOISE_W'(NOISE_MAX);
      end else if (r_wide < NOISE_MIN) begin
         noise_in = NOISE_W'(NOISE_MIN);
      end else begin
         noise_in = r_wide[NOISE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      a0_ff    <= g00;
      a1_ff    <= g01;
      d0_ff    <= d0_in;
      d1_ff    <= d1_in;
      u1_ff    <= u;
      v1_ff    <= v;
      p0_ff    <= p0_in;
      p1_ff    <= p1_in;
      a0_2_ff  <= a0_ff;
      a1_2_ff  <= a1_ff;
      v2_ff    <= v1_ff;
      low_ff   <= low_in;
      diff2_ff <= diff2_in;
      v3_ff    <= v2_ff;
      q_ff     <= q_in;
      low4_ff  <= low_ff;
      noise_ff <= noise_in;
   end

   assign noise = noise_ff;

endmodule

### rtl/gn_checker.sv
module gn_checker #(
   parameter int LAT = 28
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // The pipeline never pushes back.
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // Every accepted word yields a result at the end of the pipeline.
   a_accept_to_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("result missing after accept");

   // No result appears without a matching accept.
   a_result_has_source: assert property (@(posedge clock)
      rsp_valid |-> $past(start && !busy && !reset, LAT))
      else $error("result without accept");

   a_reset_flushes: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result right after reset");

endmodule

bind gradient_noise_2d_tileable gn_checker #(.LAT(LAT)) u_gn_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid)
);

### test/gradient_noise_2d_tileable_test.sv
`timescale 1ns / 100ps

module gradient_noise_2d_tileable_test;
   import gn_pkg::*;

   localparam int FRAC = 16;
   localparam longint ONE = longint'(1) << FRAC;
   localparam int PIPE_WAIT = 60;
   localparam int STALL_LIMIT = 5000;
   localparam logic [1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [31:0] seed;
      logic [15:0] period;
      bit known;
      logic signed [17:0] noise;
   } sample_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_coord_x = '0;
   logic signed [31:0] req_coord_y = '0;
   logic [31:0] req_hash_seed = '0;
   logic [PERIOD_W-1:0] req_tile_period = '0;
   logic csr_wr_en = 1'b0;
   logic [1:0] csr_index = CSR_MULT_ONE;
   logic [31:0] csr_wdata = '0;
   logic rsp_valid;
   logic signed [NOISE_W-1:0] rsp_noise_value;

   hash_key_type keys;
   logic signed [17:0] noise_queue[$];
   int errors = 0;
   int words_sent = 0;
   int words_checked = 0;
   int idle_cycles = 0;
   bit no_gaps = 1'b0;

   gradient_noise_2d_tileable u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .req_hash_seed(req_hash_seed), .req_tile_period(req_tile_period),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_noise_value(rsp_noise_value)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] squirrel(logic [31:0] pos, logic [31:0] seed);
      logic [31:0] m;
      m = pos * keys.mult_one;
      m = m + seed;
      m = m ^ (m >> 8);
      m = m + keys.add_two;
      m = m ^ (m << 8);
      m = m * keys.mult_three;
      m = m ^ (m >> 8);
      return m;
   endfunction

   // Arithmetic shift of the full product rounds toward minus infinity.
   function automatic longint fix_mul(longint a, longint b);
      longint p;
      p = a * b;
      return p >>> FRAC;
   endfunction

   function automatic longint fade(longint t);
      longint inner;
      inner = fix_mul(t, t * 6 - 15 * ONE) + 10 * ONE;
      return fix_mul(fix_mul(fix_mul(t, t), t), inner);
   endfunction

   function automatic longint gradient(logic [31:0] h, longint dx, longint dy);
      return (h[1] ? -dx : dx) + (h[0] ? -dy : dy);
   endfunction

   function automatic logic [31:0] corner(longint cx, longint cy, logic [31:0] seed);
      logic [31:0] inner;
      inner = squirrel(cx[31:0], seed);
      return squirrel(inner + cy[31:0], seed);
   endfunction

   function automatic logic signed [17:0] predict_noise(logic signed [31:0] x,
         logic signed [31:0] y, logic [31:0] seed, logic [15:0] period);
      longint fx, fy, cx0, cy0, cx1, cy1, u, v, lo, hi, r, per;
      fx = longint'(x) & (ONE - 1);
      fy = longint'(y) & (ONE - 1);
      cx0 = longint'(x) >>> FRAC;
      cy0 = longint'(y) >>> FRAC;
      cx1 = cx0 + 1;
      cy1 = cy0 + 1;
      per = longint'(period);
      if (per != 0) begin
         cx1 = cx1 % per;
         cy1 = cy1 % per;
      end
      u = fade(fx);
      v = fade(fy);
      lo = gradient(corner(cx0, cy0, seed), fx, fy);
      lo = lo + fix_mul(u, gradient(corner(cx1, cy0, seed), fx - ONE, fy) - lo);
      hi = gradient(corner(cx0, cy1, seed), fx, fy - ONE);
      hi = hi + fix_mul(u, gradient(corner(cx1, cy1, seed), fx - ONE, fy - ONE) - hi);
      r = lo + fix_mul(v, hi - lo);
      if (r > 131071) r = 131071;
      if (r < -131072) r = -131072;
      return r[17:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (noise_queue.size() == 0) begin
            $display("%0t: unexpected word, actual %0d", $time, rsp_noise_value);
            errors++;
         end else begin
            if (rsp_noise_value !== noise_queue[0]) begin
               $display("%0t: noise_value expected %0d actual %0d", $time,
                  noise_queue[0], rsp_noise_value);
               errors++;
            end
            void'(noise_queue.pop_front());
            words_checked++;
         end
      end
   end

   task automatic write_key(logic [1:0] idx, logic [31:0] data);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_MULT_ONE:   keys.mult_one = data;
         CSR_ADD_TWO:    keys.add_two = data;
         CSR_MULT_THREE: keys.mult_three = data;
         default: ;
      endcase
   endtask

   task automatic drain;
      while (noise_queue.size() != 0) @(negedge clock);
      repeat (PIPE_WAIT) @(negedge clock);
   endtask

   task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
         logic [31:0] seed, logic [15:0] period, bit known, logic signed [17:0] noise);
      int gap;
      logic signed [17:0] pred;
      gap = no_gaps ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_coord_x = x;
      req_coord_y = y;
      req_hash_seed = seed;
      req_tile_period = period;
      start = 1'b1;
      do @(posedge clock); while (busy);
      pred = predict_noise(x, y, seed, period);
      if (known && pred !== noise) begin
         $display("%0t: table row expected %0d predictor %0d", $time, noise, pred);
         errors++;
      end
      noise_queue.push_back(known ? noise : pred);
      words_sent++;
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return {{16{1'b0}}, 16'($urandom())} - 32'sh0000_8000 + ($urandom_range(0, 31) << 16);
         2: return -($urandom_range(0, 40) << 16) + $urandom_range(0, 65535);
         default: return ($urandom_range(0, 1) ? 32'sh7FF0_0000 : 32'sh8000_0000)
            + $urandom_range(0, 32'h000F_FFFF);
      endcase
   endfunction

   function automatic logic [15:0] pick_period();
      case ($urandom_range(0, 4))
         0: return 16'd0;
         1: return 16'($urandom_range(1, 8));
         2: return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   sample_row_type rows[] = '{
      '{32'sh0000_0000, 32'sh0000_0000, 32'h0000_0000, 16'd0, 1'b1, 18'sd0},
      '{32'sh0005_0000, 32'shFFFD_0000, 32'hFFFF_FFFF, 16'd7, 1'b1, 18'sd0},
      '{32'sh7FFF_0000, 32'sh8000_0000, 32'h1234_5678, 16'hFFFF, 1'b1, 18'sd0},
      '{32'sh8000_0000, 32'sh7FFF_0000, 32'hFFFF_FFFF, 16'd1, 1'b1, 18'sd0},
      '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 16'd0, 1'b0, 18'sd0},
      '{32'sh8000_0000, 32'sh8000_0000, 32'h0000_0000, 16'd0, 1'b0, 18'sd0},
      '{32'sh7FFF_FFFF, 32'sh8000_FFFF, 32'hA5A5_A5A5, 16'hFFFF, 1'b0, 18'sd0},
      '{32'sh0000_FFFF, 32'sh0000_0001, 32'h0000_0001, 16'd1, 1'b0, 18'sd0},
      '{32'sh0000_8000, 32'sh0000_8000, 32'hDEAD_BEEF, 16'd0, 1'b0, 18'sd0},
      '{32'shFFFF_8000, 32'shFFFF_0001, 32'h0BAD_F00D, 16'd0, 1'b0, 18'sd0},
      '{32'shFFFD_4000, 32'shFFFF_C000, 32'h0000_00FF, 16'd4, 1'b0, 18'sd0},
      '{32'shFFF0_0001, 32'shFFEF_FFFF, 32'h8000_0000, 16'd3, 1'b0, 18'sd0},
      '{32'sh0003_C000, 32'sh0002_4000, 32'h7FFF_FFFF, 16'd4, 1'b0, 18'sd0},
      '{32'sh0004_FFFF, 32'sh0009_FFFF, 32'h5555_5555, 16'd5, 1'b0, 18'sd0},
      '{32'sh7FFF_8000, 32'shFFFF_FFFF, 32'hAAAA_AAAA, 16'h8000, 1'b0, 18'sd0},
      '{32'sh1234_5678, 32'shEDCB_A987, 32'h0F0F_F0F0, 16'd2, 1'b0, 18'sd0}
   };

   initial begin
      keys = '{MULT_ONE_RST, ADD_TWO_RST, MULT_THREE_RST};
      repeat (9) @(negedge clock);
      reset = 1'b0;

      foreach (rows[i])
         send_point(rows[i].x, rows[i].y, rows[i].seed, rows[i].period,
            rows[i].known, rows[i].noise);

      // Four key settings: reset values, all zeros, all ones, random.
      for (int phase = 0; phase < 4; phase++) begin
         start = 1'b0;
         drain();
         if (phase == 1) begin
            write_key(CSR_MULT_ONE, 32'h0);
            write_key(CSR_ADD_TWO, 32'h0);
            write_key(CSR_MULT_THREE, 32'h0);
         end else if (phase == 2) begin
            write_key(CSR_MULT_ONE, 32'hFFFF_FFFF);
            write_key(CSR_ADD_TWO, 32'hFFFF_FFFF);
            write_key(CSR_MULT_THREE, 32'hFFFF_FFFF);
         end else if (phase == 3) begin
            write_key(CSR_MULT_ONE, $urandom());
            write_key(CSR_ADD_TWO, $urandom());
            write_key(CSR_MULT_THREE, $urandom());
         end
         // The spare index must leave the keys alone.
         write_key(CSR_SPARE, $urandom());
         for (int n = 0; n < 470; n++) begin
            if (n % 100 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            send_point(pick_coord(), pick_coord(), $urandom(), pick_period(), 1'b0, '0);
         end
      end
      start = 1'b0;

      while (noise_queue.size() != 0) @(negedge clock);
      repeat (PIPE_WAIT) @(negedge clock);
      $display("covered %0d words over four hash key settings, %0d results checked",
         words_sent, words_checked);
      $display("plain and wrapped tiling, signed edges and fraction extremes included");
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
